[rtl/lcp_pkg.sv]
// Shared types, codes and digit arithmetic for the line command parser.
package lcp_pkg;

	localparam int unsigned VAL_W = 32;

	// Parse phase: field * 3 + sub-phase (before sign, after sign, in digits)
	localparam logic [3:0] PH_F0_WS   = 4'd0;
	localparam logic [3:0] PH_F0_SIGN = 4'd1;
	localparam logic [3:0] PH_F0_DIG  = 4'd2;
	localparam logic [3:0] PH_F1_WS   = 4'd3;
	localparam logic [3:0] PH_F1_SIGN = 4'd4;
	localparam logic [3:0] PH_F1_DIG  = 4'd5;
	localparam logic [3:0] PH_F2_WS   = 4'd6;
	localparam logic [3:0] PH_F2_SIGN = 4'd7;
	localparam logic [3:0] PH_F2_DIG  = 4'd8;
	localparam logic [3:0] PH_DONE    = 4'd9;
	localparam logic [3:0] PH_FAIL    = 4'd10;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_OVERSIZE  = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_SEMI  = 8'd59;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

	typedef struct packed {
		logic [3:0]  phase;
		logic        neg;
		logic [31:0] accum;
		logic [31:0] first;
		logic [31:0] second;
		logic        text_ended;
	} lcp_state_t;

	// accum * 10 + d, clamped to 2^31
	function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [3:0] d);
		logic [35:0] t;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
		if (t > {4'd0, MAG_LIMIT})
			return MAG_LIMIT;
		return t[31:0];
	endfunction

	function automatic logic [31:0] signed_value(input logic neg, input logic [31:0] acc);
		if (neg) begin
			if (acc >= MAG_LIMIT)
				return MAG_LIMIT;
			return 32'd0 - acc;
		end
		if (acc > POS_MAX)
			return POS_MAX;
		return acc;
	endfunction

endpackage

[rtl/lcp_parse.sv]
// Next-state logic of the line grammar for one non-newline character.
module lcp_parse (
	input  lcp_pkg::lcp_state_t cur,
	input  logic [7:0]          ch,
	output lcp_pkg::lcp_state_t nxt
);
	import lcp_pkg::*;

	logic       is_digit;
	logic       is_space;
	logic [1:0] field;
	logic [1:0] sub;
	logic [3:0] digit;
	logic       ended;

	function automatic logic [3:0] mk_phase(input logic [1:0] f, input logic [1:0] s);
		return {2'b00, f} + {1'b0, f, 1'b0} + {2'b00, s};
	endfunction

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_space = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
	assign digit    = 4'(ch - CH_ZERO);

	always_comb begin
		case (cur.phase)
			PH_F0_WS, PH_F0_SIGN, PH_F0_DIG: field = 2'd0;
			PH_F1_WS, PH_F1_SIGN, PH_F1_DIG: field = 2'd1;
			PH_F2_WS, PH_F2_SIGN, PH_F2_DIG: field = 2'd2;
			default:                         field = 2'd3;
		endcase
		case (cur.phase)
			PH_F0_WS, PH_F1_WS, PH_F2_WS:       sub = 2'd0;
			PH_F0_SIGN, PH_F1_SIGN, PH_F2_SIGN: sub = 2'd1;
			default:                            sub = 2'd2;
		endcase
	end

	always_comb begin
		nxt   = cur;
		ended = cur.text_ended;
		if (ch == CH_NUL) begin
			// zero byte closes a third value still in its digits
			if (!cur.text_ended && cur.phase == PH_F2_DIG)
				nxt.phase = PH_DONE;
			nxt.text_ended = 1'b1;
			ended          = 1'b1;
		end
		if (!ended && field != 2'd3) begin
			if (sub == 2'd0) begin
				if (!is_space) begin
					nxt.neg   = 1'b0;
					nxt.accum = '0;
					if (ch == CH_PLUS || ch == CH_MINUS) begin
						nxt.neg   = (ch == CH_MINUS);
						nxt.phase = mk_phase(field, 2'd1);
					end else if (is_digit) begin
						nxt.accum = add_digit(32'd0, digit);
						nxt.phase = mk_phase(field, 2'd2);
					end else begin
						nxt.phase = PH_FAIL;
					end
				end
			end else if (sub == 2'd1) begin
				if (is_digit) begin
					nxt.accum = add_digit(cur.accum, digit);
					nxt.phase = mk_phase(field, 2'd2);
				end else begin
					nxt.phase = PH_FAIL;
				end
			end else begin
				if (is_digit) begin
					nxt.accum = add_digit(cur.accum, digit);
				end else if (field == 2'd2) begin
					nxt.phase = PH_DONE;
				end else if (ch == CH_SEMI) begin
					if (field == 2'd0)
						nxt.first = signed_value(cur.neg, cur.accum);
					else
						nxt.second = signed_value(cur.neg, cur.accum);
					nxt.neg   = 1'b0;
					nxt.accum = '0;
					nxt.phase = mk_phase(field + 2'd1, 2'd0);
				end else begin
					nxt.phase = PH_FAIL;
				end
			end
		end
	end

endmodule

[rtl/line_command_parser_unit.sv]
// Top level of the line command parser: input stage, line state and result register.
// Takes one character word per cycle and parses each newline-terminated line as three
// signed decimals separated by ';'. A word is held in the input register, and the parse
// update for it is written at the edge where it leaves. A newline loads the result register
// at that same edge, so its result is offered from the next cycle, one result per line.
// The sustained rate is one word per cycle.
// A line that reaches MAX_LINE characters before its newline is dropped and reported as
// oversize. The only stall comes from a held result: a newline waits in the input
// register while the previous result has not been taken, and the words behind it wait
// at the input. A word that is not a newline never waits in the input register.
module line_command_parser_unit #(
	parameter int unsigned MAX_LINE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] event_type,
	output logic signed [31:0] event_value,
	output logic signed [31:0] event_value2
);
	import lcp_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             go_s1;
	logic             nl_s1;
	logic [LEN_W-1:0] len_q;
	lcp_state_t       st_q;
	lcp_state_t       st_nxt;
	logic             oversize;
	logic [1:0]       st_code;

	lcp_parse u_parse (
		.cur (st_q),
		.ch  (byte_s1),
		.nxt (st_nxt)
	);

	assign nl_s1    = (byte_s1 == CH_NL);
	assign go_s1    = valid_s1 && (!nl_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || go_s1;
	// length stops at the limit, so reaching it marks the line oversize
	assign oversize = (len_q >= LEN_MAX);

	always_comb begin
		if (oversize)
			st_code = ST_OVERSIZE;
		else if (st_q.phase == PH_DONE || st_q.phase == PH_F2_DIG)
			st_code = ST_OK;
		else
			st_code = ST_MALFORMED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			st_q  <= '{phase: PH_F0_WS, neg: 1'b0, accum: '0, first: '0,
				second: '0, text_ended: 1'b0};
		end else if (go_s1) begin
			if (nl_s1) begin
				len_q <= '0;
				st_q  <= '{phase: PH_F0_WS, neg: 1'b0, accum: '0, first: '0,
					second: '0, text_ended: 1'b0};
			end else if (!oversize) begin
				len_q <= len_q + LEN_W'(1);
				st_q  <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go_s1 && nl_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && nl_s1) begin
			status <= st_code;
			if (st_code == ST_OK) begin
				event_type   <= st_q.first;
				event_value  <= st_q.second;
				event_value2 <= signed_value(st_q.neg, st_q.accum);
			end else begin
				event_type   <= '0;
				event_value  <= '0;
				event_value2 <= '0;
			end
		end
	end

endmodule

[verif/tb.sv]
// Testbench for line_command_parser_unit: directed and random line streams checked against a predictor.
module tb;
	import lcp_pkg::*;

	localparam int unsigned MAX_LINE = 64;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [1:0] SUB_WS   = 2'd0;
	localparam logic [1:0] SUB_SIGN = 2'd1;
	localparam logic [1:0] SUB_DIG  = 2'd2;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [1:0]  st;
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] v2;
	} line_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         in_byte;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] event_type;
	logic signed [31:0] event_value;
	logic signed [31:0] event_value2;

	line_result_t pending_lines[$];
	int           error_count;
	int           tx_idle_pct;
	int           rx_stall_pct;

	// predictor state for the line in progress
	int unsigned  line_len;
	bit           line_over;
	logic [3:0]   phase;
	bit           neg;
	logic [31:0]  mag;
	logic [31:0]  first_val;
	logic [31:0]  second_val;
	bit           text_done;

	line_command_parser_unit #(.MAX_LINE(MAX_LINE)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.event_type(event_type),
		.event_value(event_value),
		.event_value2(event_value2)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------- predictor ----------------

	task automatic clear_line();
		line_len = 0;
		line_over = 0;
		phase = PH_F0_WS;
		neg = 0;
		mag = '0;
		first_val = '0;
		second_val = '0;
		text_done = 0;
	endtask

	function automatic logic [31:0] mag_shift_in(input logic [31:0] m, input logic [7:0] c);
		longint unsigned t;
		t = longint'(m) * 10 + longint'(c - CH_ZERO);
		if (t > longint'(MAG_LIMIT))
			t = longint'(MAG_LIMIT);
		return t[31:0];
	endfunction

	function automatic logic [31:0] clamped_field(input bit n, input logic [31:0] m);
		if (n)
			return (m >= MAG_LIMIT) ? MAG_LIMIT : -m;
		return (m > POS_MAX) ? POS_MAX : m;
	endfunction

	task automatic parse_char(input logic [7:0] c);
		bit         dig;
		bit         sp;
		logic [3:0] fld;
		logic [1:0] sub;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		sp = (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
		if (phase >= PH_DONE)
			return;
		fld = 4'(phase / 3);
		sub = 2'(phase % 3);
		case (sub)
			SUB_WS: begin
				if (sp)
					return;
				neg = 0;
				mag = '0;
				if (c == CH_PLUS || c == CH_MINUS) begin
					neg = (c == CH_MINUS);
					phase = 4'(fld * 3 + SUB_SIGN);
				end else if (dig) begin
					mag = mag_shift_in(mag, c);
					phase = 4'(fld * 3 + SUB_DIG);
				end else begin
					phase = PH_FAIL;
				end
			end
			SUB_SIGN: begin
				if (dig) begin
					mag = mag_shift_in(mag, c);
					phase = 4'(fld * 3 + SUB_DIG);
				end else begin
					phase = PH_FAIL;
				end
			end
			default: begin
				if (dig) begin
					mag = mag_shift_in(mag, c);
				end else if (fld == 2) begin
					phase = PH_DONE;
				end else if (c == CH_SEMI) begin
					if (fld == 0)
						first_val = clamped_field(neg, mag);
					else
						second_val = clamped_field(neg, mag);
					neg = 0;
					mag = '0;
					phase = 4'((fld + 1) * 3 + SUB_WS);
				end else begin
					phase = PH_FAIL;
				end
			end
		endcase
	endtask

	task automatic predict_word(input logic [7:0] c);
		line_result_t r;
		if (line_len >= MAX_LINE)
			line_over = 1;
		if (c == CH_NL) begin
			r.v0 = '0;
			r.v1 = '0;
			r.v2 = '0;
			if (line_over)
				r.st = ST_OVERSIZE;
			else if (phase == PH_DONE || phase == PH_F2_DIG)
				r.st = ST_OK;
			else
				r.st = ST_MALFORMED;
			if (r.st == ST_OK) begin
				r.v0 = first_val;
				r.v1 = second_val;
				r.v2 = clamped_field(neg, mag);
			end
			pending_lines.push_back(r);
			clear_line();
			return;
		end
		if (line_over)
			return;
		line_len++;
		if (c == CH_NUL) begin
			if (!text_done && phase == PH_F2_DIG)
				phase = PH_DONE;
			text_done = 1;
		end
		if (!text_done)
			parse_char(c);
	endtask

	// ---------------- checking ----------------

	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lines.size() == 0) begin
				$display("%0t: unexpected result status=%0d values=%0d %0d %0d", $time,
					status, event_type, event_value, event_value2);
				error_count++;
			end else begin
				want = pending_lines.pop_front();
				if (status !== want.st || event_type !== want.v0 ||
						event_value !== want.v1 || event_value2 !== want.v2) begin
					$display("%0t: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
						$time, want.st, $signed(want.v0), $signed(want.v1), $signed(want.v2),
						status, event_type, event_value, event_value2);
					error_count++;
				end
			end
		end
	end

	// ---------------- driving ----------------

	task automatic send_word(input logic [7:0] c);
		@(negedge clk);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_byte <= c;
		do @(posedge clk); while (!in_ready);
		predict_word(c);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i]);
	endtask

	// sender holds off until every line result is back
	task automatic wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------- random line builder ----------------

	function automatic logic [7:0] any_but_nl();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_NL);
		return b;
	endfunction

	function automatic void add_text(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	function automatic void add_number(ref logic [7:0] q[$]);
		int         n;
		int         sel;
		logic [7:0] w;
		if ($urandom_range(3) == 0) begin
			n = $urandom_range(1, 2);
			repeat (n) begin
				w = 8'($urandom_range(8, 13));
				q.push_back((w == CH_NL || w < CH_TAB) ? CH_SPACE : w);
			end
		end
		case ($urandom_range(3))
			0: q.push_back(CH_PLUS);
			1: q.push_back(CH_MINUS);
			default: ;
		endcase
		sel = $urandom_range(99);
		if (sel < 8) begin
			case ($urandom_range(2))
				0: add_text(q, "2147483647");
				1: add_text(q, "2147483648");
				default: add_text(q, "2147483649");
			endcase
		end else begin
			if (sel < 75)
				n = $urandom_range(1, 3);
			else if (sel < 92)
				n = $urandom_range(4, 9);
			else
				n = $urandom_range(10, 12);
			repeat (n) q.push_back(8'(CH_ZERO + $urandom_range(9)));
		end
	endfunction

	function automatic void build_line(ref logic [7:0] q[$]);
		int kind;
		int n;
		q.delete();
		kind = $urandom_range(99);
		if (kind < 85 || kind >= 92) begin
			for (int f = 0; f < 3; f++) begin
				add_number(q);
				if (f < 2)
					q.push_back(CH_SEMI);
			end
			if ($urandom_range(2) == 0) begin
				n = $urandom_range(1, 5);
				repeat (n) q.push_back(($urandom_range(7) == 0) ? CH_NUL : any_but_nl());
			end
		end
		if (kind >= 70 && kind < 80) begin
			q[$urandom_range(q.size() - 1)] = ($urandom_range(4) == 0) ? CH_NUL : any_but_nl();
		end else if (kind >= 80 && kind < 85) begin
			n = $urandom_range(1, q.size());
			repeat (n) void'(q.pop_back());
		end else if (kind >= 85 && kind < 92) begin
			n = $urandom_range(10);
			repeat (n) begin
				case ($urandom_range(3))
					0: q.push_back(8'(CH_ZERO + $urandom_range(9)));
					1: q.push_back(CH_SEMI);
					2: q.push_back(CH_MINUS);
					default: q.push_back(any_but_nl());
				endcase
			end
		end else if (kind >= 92) begin
			// pad around the line limit
			n = $urandom_range(MAX_LINE - 3, MAX_LINE + 8);
			while (q.size() < n)
				q.push_back(any_but_nl());
		end
		q.push_back(CH_NL);
	endfunction

	// ---------------- tests ----------------

	task automatic test_field_grammar();
		send_str(" +1;\t-2;3 x\n");
		send_str("\n");
		send_str("1 ;2;3\n");
		send_str("1;2\n");
		send_str("1;2;-\n");
		send_str("1;");
		send_word(8'd200);
		send_str(";3\n");
	endtask

	task automatic test_saturation();
		send_str("-2147483649;2147483648;-99999999999\n");
		send_str("-2147483648;2147483647;0\n");
	endtask

	task automatic test_text_end();
		send_str("1;2;3");
		send_word(CH_NUL);
		send_str("junk\n");
		send_str("4;5");
		send_word(CH_NUL);
		send_str(";6\n");
	endtask

	task automatic test_line_limit();
		send_str("1;2;3");
		repeat (MAX_LINE - 6) send_word("x");
		send_str("\n");
		send_str("1;2;3");
		repeat (MAX_LINE - 5) send_word("x");
		send_str("\n");
		repeat (MAX_LINE + 16) send_word("9");
		send_str("\n7;8;9\n");
	endtask

	task automatic test_random_lines(input int n_words, input int tx_pct, input int rx_pct);
		logic [7:0] line[$];
		int         sent;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		sent = 0;
		while (sent < n_words) begin
			build_line(line);
			foreach (line[i])
				send_word(line[i]);
			sent += line.size();
		end
		wait_results();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		out_ready = 1'b0;
		error_count = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		clear_line();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_grammar();
		test_saturation();
		test_text_end();
		test_line_limit();
		wait_results();
		test_random_lines(220, 0, 0);
		test_random_lines(220, 66, 0);
		test_random_lines(220, 0, 66);
		test_random_lines(220, 21, 21);

		if (error_count == 0 && pending_lines.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[line_command_parser_unit.f]
rtl/lcp_pkg.sv
rtl/lcp_parse.sv
rtl/line_command_parser_unit.sv
verif/tb.sv
